/* hdl/frame_difference_motion_mask_core_macros.svh */
// Assertion macros for the frame difference motion mask core.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef FRAME_DIFFERENCE_MOTION_MASK_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_MASK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define FDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define FDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FDM_ASSERT_NOW(lbl, ante, cons, msg)
`define FDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/fdm_pkg.sv */
// Shared types and constants for the frame difference motion mask core.
// No dependencies; imported by fdm_rect_table, the core and the testbench, not by fdm_frame_ram.
package fdm_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    ACT_PIXEL       = 2'd0,
    ACT_ADD_RECT    = 2'd1,
    ACT_CLEAR_RECTS = 2'd2,
    ACT_CLEAR_FRAME = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_BORDER_X   = 3'd1,
    CFG_BORDER_Y   = 3'd2,
    CFG_FRAME_COLS = 3'd3,
    CFG_FRAME_ROWS = 3'd4
  } cfg_reg_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Rectangle edges as loaded: left/top inclusive, right/bottom exclusive
  typedef struct packed {
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] right;
    logic [9:0] bottom;
  } rect_edges_t;

  // Commands from the sequencer to the rectangle table
  typedef struct packed {
    logic load;
    logic clear;
  } rect_cmd_t;

  // Status from the rectangle table
  typedef struct packed {
    logic hit;
    logic full;
  } rect_status_t;

  localparam logic [7:0] FORCED_LEVEL    = 8'd255;
  localparam logic [7:0] RESET_THRESHOLD = 8'd10;
  localparam logic [9:0] RESET_IMAGE_DIM = 10'd512;

  // floor(d/3) == (d * 683) >> 11 for every 10-bit d
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

endpackage

/* hdl/fdm_frame_ram.sv */
// Previous-frame pixel store: one write port, one read port, registered read data.
// No package dependencies.
module fdm_frame_ram #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fdm_rect_table.sv */
// Mask rectangle table: stores shrunk rectangles in lanes and tests a pixel against all.
// Depends on fdm_pkg for the edge and command structs and the divide-by-three constants.
module fdm_rect_table
  import fdm_pkg::*;
#(
  parameter int MAX_RECTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  rect_cmd_t    cmd,
  input  rect_edges_t  edges,
  input  logic [8:0]   pixel_x,
  input  logic [8:0]   pixel_y,
  output rect_status_t status
);

  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  logic [CW-1:0] rect_count;
  logic [9:0]    lane_x_lo [0:MAX_RECTS-1];
  logic [9:0]    lane_x_hi [0:MAX_RECTS-1];
  logic [9:0]    lane_y_lo [0:MAX_RECTS-1];
  logic [9:0]    lane_y_hi [0:MAX_RECTS-1];
  logic          lane_live [0:MAX_RECTS-1];
  logic [MAX_RECTS-1:0] lane_hit;

  logic [9:0]  dx, dy;
  logic [19:0] prod_x, prod_y;
  logic [8:0]  ax, ay;
  logic        nonempty;

  // Shrink the incoming rectangle by a third of its size on each side
  always_comb begin
    dx       = edges.right - edges.left;
    dy       = edges.bottom - edges.top;
    prod_x   = {10'd0, dx} * {10'd0, RECIP3};
    prod_y   = {10'd0, dy} * {10'd0, RECIP3};
    ax       = prod_x[RECIP3_SHIFT +: 9];
    ay       = prod_y[RECIP3_SHIFT +: 9];
    nonempty = (edges.right > edges.left) && (edges.bottom > edges.top);
  end

  // Count loaded rectangles
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count <= '0;
    end else if (cmd.clear) begin
      rect_count <= '0;
    end else if (cmd.load && !status.full) begin
      rect_count <= rect_count + CW'(1);
    end
  end

  // Write the shrunk box into the next free lane
  always_ff @(posedge clk) begin
    if (cmd.load && !status.full) begin
      lane_x_lo[rect_count[IW-1:0]] <= edges.left + {1'b0, ax};
      lane_x_hi[rect_count[IW-1:0]] <= edges.right - {1'b0, ax};
      lane_y_lo[rect_count[IW-1:0]] <= edges.top + {1'b0, ay};
      lane_y_hi[rect_count[IW-1:0]] <= edges.bottom - {1'b0, ay};
      lane_live[rect_count[IW-1:0]] <= nonempty;
    end
  end

  // Test the pixel against every loaded lane in parallel
  always_comb begin
    for (int i = 0; i < MAX_RECTS; i++) begin
      lane_hit[i] = (CW'(i) < rect_count) && lane_live[i] &&
                    ({1'b0, pixel_x} >= lane_x_lo[i]) && ({1'b0, pixel_x} < lane_x_hi[i]) &&
                    ({1'b0, pixel_y} >= lane_y_lo[i]) && ({1'b0, pixel_y} < lane_y_hi[i]);
    end
    status.hit  = |lane_hit;
    status.full = (rect_count == CW'(MAX_RECTS));
  end

endmodule

/* hdl/frame_difference_motion_mask_core.sv */
// Frame difference motion mask core. An item is accepted in the idle state, which issues the
// read of the previous pixel from the single-port-pair frame store; the lookup state then
// compares, writes the new pixel back and loads the output register, which then frees the
// input side. An item is taken while the previous result still waits on the output side; the
// lookup cycle holds only if that result is still not taken. After reset, and after each
// clear-frame item, the frame store is zeroed one entry a cycle, all MAX_WIDTH*MAX_HEIGHT entries
// (262144 at the default size), during which no item is taken; configuration writes work as
// usual. Depends on fdm_pkg, fdm_frame_ram, fdm_rect_table and the assertion macro header.
`include "frame_difference_motion_mask_core_macros.svh"

module frame_difference_motion_mask_core
  import fdm_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RECTS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: pixel_x[8:0], pixel_y[17:9], pixel_value[25:18], rect_left[35:26],
  //          rect_top[45:36], rect_right[55:46], rect_bottom[65:56], zero pad[71:66]
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,  // action[1:0]
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: motion[0], out_x[9:1], out_y[18:10], rect_dropped[19], zero pad[23:20]
  output logic [23:0] m_tdata,
  output logic [1:0]  m_tuser   // kind[1:0]
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 10;
  localparam int CAP_W = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam int CAP_H = (MAX_HEIGHT < 1023) ? MAX_HEIGHT : 1023;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Configuration registers
  logic [7:0] threshold;
  logic [8:0] border_x;
  logic [8:0] border_y;
  logic [9:0] frame_cols;
  logic [9:0] frame_rows;

  // Sequencer
  state_t state, state_next;
  logic [AW-1:0] clr_addr;

  // Item held through the lookup cycle
  action_t     act_q;
  logic [8:0]  px_q, py_q;
  logic [7:0]  pv_q;
  rect_edges_t edges_q;
  logic        in_range_q, band_q, hit_q;
  logic [AW-1:0] addr_q;

  // Unpacked input fields
  action_t     in_act;
  logic [8:0]  in_px, in_py;
  logic [7:0]  in_pv;
  rect_edges_t in_edges;

  // Combinational per-item terms
  logic [9:0]    w_act, h_act;
  logic          in_range_d, band_x, band_y;
  logic [PW-1:0] addr_wide;
  logic          accept;

  // Store and rectangle table interface
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  rect_cmd_t     rect_cmd;
  rect_status_t  rect_stat;

  // Result terms
  logic [7:0] diff, level;
  logic       motion_d;
  logic       out_load;

  assign in_act   = action_t'(s_tuser);
  assign in_px    = s_tdata[8:0];
  assign in_py    = s_tdata[17:9];
  assign in_pv    = s_tdata[25:18];
  assign in_edges = '{left: s_tdata[35:26], top: s_tdata[45:36],
                      right: s_tdata[55:46], bottom: s_tdata[65:56]};
  assign accept   = s_tvalid && s_tready;

  // Take configuration writes at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= RESET_THRESHOLD;
      border_x   <= '0;
      border_y   <= '0;
      frame_cols <= RESET_IMAGE_DIM;
      frame_rows <= RESET_IMAGE_DIM;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD:  threshold  <= cfg_data[7:0];
        CFG_BORDER_X:   border_x   <= cfg_data[8:0];
        CFG_BORDER_Y:   border_y   <= cfg_data[8:0];
        CFG_FRAME_COLS: frame_cols <= cfg_data;
        CFG_FRAME_ROWS: frame_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active size, range, border band and store address of the incoming pixel
  always_comb begin
    w_act      = (frame_cols < 10'(CAP_W)) ? frame_cols : 10'(CAP_W);
    h_act      = (frame_rows < 10'(CAP_H)) ? frame_rows : 10'(CAP_H);
    in_range_d = ({1'b0, in_px} < w_act) && ({1'b0, in_py} < h_act);
    band_x     = ({border_x, 1'b0} < w_act) && (in_px >= border_x) &&
                 ({1'b0, in_px} < (w_act - {1'b0, border_x}));
    band_y     = ({border_y, 1'b0} < h_act) && (in_py >= border_y) &&
                 ({1'b0, in_py} < (h_act - {1'b0, border_y}));
    addr_wide  = PW'(in_py) * PW'(MAX_WIDTH) + PW'(in_px);
  end

  // Compare against the stored pixel
  always_comb begin
    diff     = (pv_q >= ram_rdata) ? (pv_q - ram_rdata) : (ram_rdata - pv_q);
    level    = hit_q ? FORCED_LEVEL : diff;
    motion_d = (act_q == ACT_PIXEL) && in_range_q && band_q && (level > threshold);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, store access and rectangle commands
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = pv_q;
    out_load      = 1'b0;
    rect_cmd      = '{load: 1'b0, clear: 1'b0};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ram_re     = (in_act == ACT_PIXEL) && in_range_d;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!m_tvalid || m_tready) begin
          out_load       = 1'b1;
          ram_we         = (act_q == ACT_PIXEL) && in_range_q;
          rect_cmd.load  = (act_q == ACT_ADD_RECT);
          rect_cmd.clear = (act_q == ACT_CLEAR_RECTS);
          state_next     = (act_q == ACT_CLEAR_FRAME) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Clear address walks the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + AW'(1);
    end
  end

  // Hold the accepted item through the lookup cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q      <= in_act;
      px_q       <= in_px;
      py_q       <= in_py;
      pv_q       <= in_pv;
      edges_q    <= in_edges;
      in_range_q <= in_range_d;
      band_q     <= band_x && band_y;
      hit_q      <= rect_stat.hit;
      addr_q     <= addr_wide[AW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser         <= act_q;
      m_tdata[0]      <= motion_d;
      m_tdata[9:1]    <= (act_q == ACT_PIXEL) ? px_q : 9'd0;
      m_tdata[18:10]  <= (act_q == ACT_PIXEL) ? py_q : 9'd0;
      m_tdata[19]     <= (act_q == ACT_ADD_RECT) && rect_stat.full;
      m_tdata[23:20]  <= 4'd0;
    end
  end

  fdm_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_wide[AW-1:0]),
    .rdata (ram_rdata)
  );

  fdm_rect_table #(
    .MAX_RECTS (MAX_RECTS)
  ) u_rect_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (rect_cmd),
    .edges   (edges_q),
    .pixel_x (in_px),
    .pixel_y (in_py),
    .status  (rect_stat)
  );

  // Checks
  `FDM_ASSERT_NEXT(a_accept_enters_lookup, accept, state == ST_LOOKUP, "accepted item skipped lookup")
  `FDM_ASSERT_NEXT(a_lookup_waits_for_output, state == ST_LOOKUP && m_tvalid && !m_tready, state == ST_LOOKUP && m_tvalid, "result dropped while output stalled")
  `FDM_ASSERT_NOW(a_no_read_during_write, ram_we, !ram_re, "store read and written in one cycle")
  `FDM_ASSERT_NEXT(a_clear_finishes, state == ST_CLEAR && clr_addr == LAST_ADDR, state == ST_IDLE && clr_addr == '0, "store clear did not finish")

endmodule

/* tb/frame_difference_motion_mask_core_tb.sv */
// Self-checking testbench for frame_difference_motion_mask_core: stream driver, result
// monitor and a behavioral motion-mask predictor with its own frame store and rectangle list.
// Depends on fdm_pkg and the core RTL only.
module frame_difference_motion_mask_core_tb
  import fdm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W     = 512;
  localparam int FRAME_H     = 512;
  localparam int RECT_SLOTS  = 8;
  localparam int SHRINK_DIV  = 3;
  // Each frame clear walks 262144 entries with nothing accepted; allow several of those
  localparam int STALL_LIMIT = 1000000;

  typedef struct {
    action_t    act;
    logic [8:0] px;
    logic [8:0] py;
    logic [7:0] pv;
    logic [9:0] rl;
    logic [9:0] rt;
    logic [9:0] rr;
    logic [9:0] rb;
  } fdm_item_t;

  typedef struct {
    action_t    kind;
    logic       motion;
    logic [8:0] x;
    logic [8:0] y;
    logic       dropped;
  } motion_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predictor state and register copies
  logic [7:0]  prev_frame [0:FRAME_W*FRAME_H-1];
  rect_edges_t rect_list [0:RECT_SLOTS-1];
  int          rect_cnt;
  int          thr_reg;
  int          border_x_reg;
  int          border_y_reg;
  int          width_reg;
  int          height_reg;

  fdm_item_t      items_to_send[$];
  motion_result_t motion_results_due[$];
  fdm_item_t      in_flight;
  int             src_idle_pct = 0;
  int             sink_stall_pct = 0;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;

  frame_difference_motion_mask_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit in_band(int pos, int border, int size);
    if (2 * border >= size) return 1'b0;
    return pos >= border && pos < size - border;
  endfunction

  // Rectangle shrunk by a third of its width and height on each side
  function automatic bit in_shrunk_rect(rect_edges_t r, int x, int y);
    int l, t, rr, b, ax, ay;
    l = int'(r.left);
    t = int'(r.top);
    rr = int'(r.right);
    b = int'(r.bottom);
    if (rr <= l || b <= t) return 1'b0;
    ax = (rr - l) / SHRINK_DIV;
    ay = (b - t) / SHRINK_DIV;
    return x >= l + ax && x < rr - ax && y >= t + ay && y < b - ay;
  endfunction

  // Apply one item to the predictor state and return the motion result it gives
  function automatic motion_result_t compute_motion_result(fdm_item_t it);
    motion_result_t res;
    int w, h, x, y, v, addr, old, level;
    res.kind = it.act;
    res.motion = 1'b0;
    res.x = '0;
    res.y = '0;
    res.dropped = 1'b0;
    case (it.act)
      ACT_PIXEL: begin
        w = (width_reg < FRAME_W) ? width_reg : FRAME_W;
        h = (height_reg < FRAME_H) ? height_reg : FRAME_H;
        x = int'(it.px);
        y = int'(it.py);
        v = int'(it.pv);
        res.x = it.px;
        res.y = it.py;
        if (x < w && y < h) begin
          addr = y * FRAME_W + x;
          old = int'(prev_frame[addr]);
          level = (v >= old) ? v - old : old - v;
          for (int i = 0; i < rect_cnt; i++) begin
            if (in_shrunk_rect(rect_list[i], x, y)) begin
              level = int'(FORCED_LEVEL);
              break;
            end
          end
          if (in_band(x, border_x_reg, w) && in_band(y, border_y_reg, h) && level > thr_reg)
            res.motion = 1'b1;
          prev_frame[addr] = it.pv;
        end
      end
      ACT_ADD_RECT: begin
        if (rect_cnt < RECT_SLOTS) begin
          rect_list[rect_cnt] = '{left: it.rl, top: it.rt, right: it.rr, bottom: it.rb};
          rect_cnt++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      ACT_CLEAR_RECTS: rect_cnt = 0;
      default: begin
        foreach (prev_frame[i]) prev_frame[i] = '0;
      end
    endcase
    return res;
  endfunction

  // Send items from the pending queue; hold valid until the item is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        motion_results_due.push_back(compute_motion_result(in_flight));
      if (!s_tvalid || s_tready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_flight = items_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'd0, in_flight.rb, in_flight.rr, in_flight.rt, in_flight.rl,
                      in_flight.pv, in_flight.py, in_flight.px};
          s_tuser <= in_flight.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check each result against the oldest prediction; watch for a hung stream
  always @(posedge clk) begin
    motion_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = action_t'(m_tuser);
      got.motion = m_tdata[0];
      got.x = m_tdata[9:1];
      got.y = m_tdata[18:10];
      got.dropped = m_tdata[19];
      if (motion_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind=%0d motion=%0d x=%0d y=%0d dropped=%0d",
                   got.kind, got.motion, got.x, got.y, got.dropped);
      end else begin
        want = motion_results_due.pop_front();
        if (got.kind !== want.kind || got.motion !== want.motion || got.x !== want.x ||
            got.y !== want.y || got.dropped !== want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind=%0d motion=%0d x=%0d y=%0d dropped=%0d, got kind=%0d motion=%0d x=%0d y=%0d dropped=%0d",
                     want.kind, want.motion, want.x, want.y, want.dropped,
                     got.kind, got.motion, got.x, got.y, got.dropped);
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("frame_difference_motion_mask_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic push_item(action_t a, int px, int py, int pv, int rl, int rt, int rr, int rb);
    fdm_item_t it;
    it.act = a;
    it.px = 9'(px);
    it.py = 9'(py);
    it.pv = 8'(pv);
    it.rl = 10'(rl);
    it.rt = 10'(rt);
    it.rr = 10'(rr);
    it.rb = 10'(rb);
    items_to_send.push_back(it);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[9:0];
    case (idx)
      CFG_THRESHOLD:  thr_reg = value;
      CFG_BORDER_X:   border_x_reg = value;
      CFG_BORDER_Y:   border_y_reg = value;
      CFG_FRAME_COLS: width_reg = value;
      default:        height_reg = value;
    endcase
  endtask

  // Wait until every item is sent and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (items_to_send.size() != 0 || s_tvalid || motion_results_due.size() != 0)
      @(negedge clk);
  endtask

  // Mostly near either end of the active range so pixels get revisited
  function automatic int pick_coord(int size);
    int r, win;
    r = $urandom_range(99);
    win = (size < 8) ? size : 8;
    if (r < 50) return $urandom_range(win - 1);
    if (r < 70) return size - 1 - $urandom_range(win - 1);
    if (r < 90) return $urandom_range(size - 1);
    return $urandom_range(511);
  endfunction

  function automatic int pick_edge();
    if ($urandom_range(9) == 0) return 512;
    return $urandom_range(512);
  endfunction

  task automatic queue_random(int count, bit with_frame_clear);
    int w, h, r, l, t, rr, b, px, py;
    w = (width_reg < FRAME_W) ? width_reg : FRAME_W;
    h = (height_reg < FRAME_H) ? height_reg : FRAME_H;
    for (int n = 0; n < count; n++) begin
      if (with_frame_clear && n == count / 2) begin
        push_item(ACT_CLEAR_FRAME, $urandom_range(511), $urandom_range(511),
                  $urandom_range(255), pick_edge(), pick_edge(), pick_edge(), pick_edge());
        continue;
      end
      px = pick_coord(w);
      py = pick_coord(h);
      // Small rectangles near the low corner, now and then anything at all
      if ($urandom_range(4) == 0) begin
        l = pick_edge();
        t = pick_edge();
        rr = pick_edge();
        b = pick_edge();
      end else begin
        l = $urandom_range(10);
        t = $urandom_range(10);
        rr = l + $urandom_range(14);
        b = t + $urandom_range(14);
      end
      r = $urandom_range(99);
      if (r < 82)
        push_item(ACT_PIXEL, px, py, $urandom_range(255), l, t, rr, b);
      else if (r < 94)
        push_item(ACT_ADD_RECT, px, py, $urandom_range(255), l, t, rr, b);
      else
        push_item(ACT_CLEAR_RECTS, px, py, $urandom_range(255), l, t, rr, b);
    end
  endtask

  task automatic run_phase(int thr, int bx, int by, int w, int h, int src_pct, int sink_pct,
                           int count, bit with_frame_clear);
    wait_drained();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_BORDER_X, bx);
    write_reg(CFG_BORDER_Y, by);
    write_reg(CFG_FRAME_COLS, w);
    write_reg(CFG_FRAME_ROWS, h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    queue_random(count, with_frame_clear);
  endtask

  initial begin
    foreach (prev_frame[i]) prev_frame[i] = '0;
    rect_cnt = 0;
    thr_reg = int'(RESET_THRESHOLD);
    border_x_reg = 0;
    border_y_reg = 0;
    width_reg = int'(RESET_IMAGE_DIM);
    height_reg = int'(RESET_IMAGE_DIM);

    // Directed items under the reset register values
    push_item(ACT_PIXEL, 0, 0, 255, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 511, 511, 255, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 0, 0, 10, 0, 0, 0, 0);       // difference equals threshold
    push_item(ACT_PIXEL, 0, 0, 21, 0, 0, 0, 0);       // one above threshold
    push_item(ACT_ADD_RECT, 0, 0, 0, 0, 0, 512, 512);
    push_item(ACT_ADD_RECT, 0, 0, 0, 4, 4, 4, 10);    // empty rectangle
    push_item(ACT_ADD_RECT, 0, 0, 0, 10, 10, 5, 20);  // inverted rectangle
    push_item(ACT_ADD_RECT, 0, 0, 0, 100, 100, 109, 109);
    push_item(ACT_PIXEL, 104, 104, 0, 0, 0, 0, 0);    // forced level inside shrunk box
    push_item(ACT_PIXEL, 200, 200, 0, 0, 0, 0, 0);
    push_item(ACT_ADD_RECT, 0, 0, 0, 511, 511, 512, 512);
    push_item(ACT_ADD_RECT, 0, 0, 0, 0, 0, 3, 3);
    push_item(ACT_ADD_RECT, 0, 0, 0, 512, 512, 512, 512);
    push_item(ACT_ADD_RECT, 0, 0, 0, 1, 2, 511, 510);
    push_item(ACT_ADD_RECT, 511, 511, 255, 5, 5, 50, 50); // list full, dropped
    push_item(ACT_CLEAR_RECTS, 0, 0, 0, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 104, 104, 0, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 511, 0, 128, 0, 0, 0, 0);
    push_item(ACT_CLEAR_FRAME, 0, 0, 0, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 0, 0, 21, 0, 0, 0, 0);
    push_item(ACT_PIXEL, 511, 511, 255, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Random phases: register settings, then sender and receiver idling
    run_phase(0, 0, 0, 512, 512, 0, 0, 260, 1'b0);
    run_phase(255, 3, 0, 512, 1, 87, 0, 260, 1'b0);
    run_phase(40, 256, 2, 512, 24, 0, 87, 260, 1'b1);
    run_phase(20, 2, 3, 24, 17, 11, 11, 260, 1'b0);
    run_phase(5, 0, 0, 1, 300, 0, 0, 260, 1'b0);
    run_phase(70, 5, 256, 40, 512, 11, 11, 260, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && motion_results_due.size() == 0) begin
      $display("frame_difference_motion_mask_core_tb: PASS");
    end else begin
      $display("frame_difference_motion_mask_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/fdm_pkg.sv
hdl/fdm_frame_ram.sv
hdl/fdm_rect_table.sv
hdl/frame_difference_motion_mask_core.sv
tb/frame_difference_motion_mask_core_tb.sv
